// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SVS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SVS_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== sv/svs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// svs_pkg
// Types and constants shared by the strided vector scatter modules.
// ---------------------------------------------------------------------------
package svs_pkg;

	localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;
	localparam int unsigned MAX_RESULTS          = 33;
	localparam int unsigned MIN_BLOCK_BYTES      = 64;
	localparam int unsigned DIV_STEPS            = 32;
	localparam int unsigned DIV_CNT_W            = $clog2(DIV_STEPS);
	localparam int unsigned PIECE_CNT_W          = $clog2(MAX_RESULTS);

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned PBYTES_W = 12;
	localparam int unsigned PIECE_W  = 12;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_BYTES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_BASE = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;   // latch a new packet, start the divide
		logic step;   // one divide step
		logic emit;   // write current piece to the output register, advance
	} svs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pkt_empty;   // incoming packet has no bytes
		logic div_done;    // final divide step this cycle
		logic piece_last;  // current piece closes the packet
		logic piece_wrap;  // message offset wraps after current piece
		logic out_free;    // output register can take a piece
	} svs_sts_t;

endpackage
`default_nettype wire

// ===== sv/svs_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// svs_ctrl
// Sequencer: accept a packet, run the divide, then emit its pieces; an empty packet skips both, a wrap divides again.
// ---------------------------------------------------------------------------
module svs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pkt_valid,
	output logic              pkt_stall,
	input  svs_pkg::svs_sts_t sts,
	output svs_pkg::svs_cmd_t cmd
);
	import svs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		pkt_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				pkt_stall = 1'b0;
				cmd.load  = pkt_valid;
				if (pkt_valid && !sts.pkt_empty) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) begin
					if (sts.piece_last) begin
						state_d = ST_IDLE;
					end else if (sts.piece_wrap) begin
						state_d = ST_DIV;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SVS_ASSERT(a_cmd_excl, $onehot0({cmd.load, cmd.step, cmd.emit}), "commands overlap")
	`SVS_ASSERT(a_div_to_emit, (state_q == ST_DIV && sts.div_done) |=> (state_q == ST_EMIT), "divide end lost")
	`SVS_ASSERT(a_last_to_idle, (cmd.emit && sts.piece_last) |=> (state_q == ST_IDLE), "last piece did not end packet")

endmodule
`default_nettype wire

// ===== sv/svs_dpath.sv =====
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// svs_dpath
// Config registers, shift-subtract divider with folded index*pitch product,
// piece splitter and output register.
// ---------------------------------------------------------------------------
module svs_dpath #(
	parameter int unsigned MAX_PACKET_BYTES = svs_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [svs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svs_pkg::WORD_W-1:0]          cfg_data,
	input  logic [svs_pkg::WORD_W-1:0]          packet_offset,
	input  logic [svs_pkg::PBYTES_W-1:0]        packet_bytes,
	input  svs_pkg::svs_cmd_t                   cmd,
	output svs_pkg::svs_sts_t                   sts,
	input  logic                                piece_stall,
	output logic                                piece_valid,
	output logic [svs_pkg::ADDR_W-1:0]          host_address,
	output logic [svs_pkg::PIECE_W-1:0]         piece_bytes,
	output logic [svs_pkg::POS_W-1:0]           packet_position,
	output logic                                last_piece
);
	import svs_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_PACKET_BYTES + 1);

	// Configuration
	logic [WORD_W-1:0] block_bytes_q, gap_bytes_q, message_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q  <= WORD_W'(MIN_BLOCK_BYTES);
			gap_bytes_q    <= '0;
			message_base_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_BLOCK_BYTES:  block_bytes_q  <= cfg_data;
				REG_GAP_BYTES:    gap_bytes_q    <= cfg_data;
				REG_MESSAGE_BASE: message_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WORD_W-1:0] blk;
	logic [WORD_W:0]   pitch;
	assign blk   = (block_bytes_q < WORD_W'(MIN_BLOCK_BYTES)) ? WORD_W'(MIN_BLOCK_BYTES)
	                                                          : block_bytes_q;
	assign pitch = {1'b0, blk} + {1'b0, gap_bytes_q};

	// Packet state
	logic [WORD_W-1:0]      here_q, dvd_q, rem_q;
	logic [ADDR_W-1:0]      prod_q;
	logic [LEN_W-1:0]       len_q, pos_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [PIECE_CNT_W-1:0] n_q;

	logic [WORD_W-1:0] start;
	logic [LEN_W-1:0]  len_in;
	assign start  = message_base_q + packet_offset;
	assign len_in = (WORD_W'(packet_bytes) > WORD_W'(MAX_PACKET_BYTES)) ?
	                LEN_W'(MAX_PACKET_BYTES) : LEN_W'(packet_bytes);

	// Divide step: remainder ends as offset in block, product as index*pitch
	logic [WORD_W:0]   trial, trial_sub;
	logic              q_bit;
	logic [WORD_W-1:0] rem_n;
	logic [ADDR_W-1:0] prod_n;
	assign trial     = {rem_q, dvd_q[WORD_W-1]};
	assign trial_sub = trial - {1'b0, blk};
	assign q_bit     = (trial >= {1'b0, blk});
	assign rem_n     = q_bit ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
	assign prod_n    = {prod_q[ADDR_W-2:0], 1'b0} + (q_bit ? ADDR_W'(pitch) : '0);

	// Piece split
	logic [WORD_W-1:0] room;
	logic [LEN_W-1:0]  left, size;
	logic [WORD_W:0]   next_here;
	logic              fits;
	assign room      = blk - rem_q;
	assign left      = len_q - pos_q;
	assign fits      = (room >= WORD_W'(left));
	assign size      = fits ? left : LEN_W'(room);
	assign next_here = {1'b0, here_q} + (WORD_W + 1)'(size);

	assign sts.pkt_empty  = (packet_bytes == '0);
	assign sts.div_done   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign sts.piece_last = fits || (n_q == PIECE_CNT_W'(MAX_RESULTS - 1));
	assign sts.piece_wrap = next_here[WORD_W];
	assign sts.out_free   = !piece_valid || !piece_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			here_q <= start;
			dvd_q  <= start;
			rem_q  <= '0;
			prod_q <= '0;
			len_q  <= len_in;
			pos_q  <= '0;
		end else if (cmd.step) begin
			rem_q  <= rem_n;
			prod_q <= prod_n;
			dvd_q  <= {dvd_q[WORD_W-2:0], 1'b0};
		end else if (cmd.emit && !sts.piece_last) begin
			pos_q  <= pos_q + size;
			here_q <= next_here[WORD_W-1:0];
			rem_q  <= '0;
			if (sts.piece_wrap) begin
				// offset wrapped: divide the new offset from scratch
				dvd_q  <= next_here[WORD_W-1:0];
				prod_q <= '0;
			end else begin
				prod_q <= prod_q + ADDR_W'(pitch);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
		end else begin
			if (cmd.load || (cmd.emit && sts.piece_wrap)) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.emit) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// Output register
	logic [ADDR_W-1:0]  addr_q;
	logic [PIECE_W-1:0] size_q;
	logic [POS_W-1:0]   opos_q;
	logic               last_q, valid_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			addr_q <= prod_q + ADDR_W'(rem_q);
			size_q <= PIECE_W'(size);
			opos_q <= POS_W'(pos_q);
			last_q <= sts.piece_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!piece_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign piece_valid     = valid_q;
	assign host_address    = addr_q;
	assign piece_bytes     = size_q;
	assign packet_position = opos_q;
	assign last_piece      = last_q;

	`SVS_ASSERT(a_rem_bound, cmd.step |-> (rem_q < blk), "divide remainder out of range")
	`SVS_NEVER(a_zero_piece, cmd.emit && (size == '0), "zero-size piece emitted")

endmodule
`default_nettype wire

// ===== sv/strided_vector_segment_scatter_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// strided_vector_segment_scatter_core
// Split one packet into the pieces of a strided vector layout in host memory.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                                   Moves
//  -------   ---------------------------------------   -----------------------
//  pkt       pkt_valid / pkt_stall                     packet_offset, packet_bytes
//  piece     piece_valid / piece_stall                 host_address, piece_bytes,
//                                                      packet_position, last_piece
//  cfg       cfg_write_en, cfg_index, cfg_data         block_bytes, gap_bytes,
//                                                      message_base
//
//  The divider produces one quotient bit per cycle: an accepted non-empty item
//    runs the divide, then its pieces are emitted, and a wrap of the 32-bit
//    message offset inside the packet runs the divide again before the next piece.
//  The block takes one item at a time; pkt_stall is low only while idle.
//  The piece output register decouples the sides: the next item is accepted
//    while the final piece of the previous one still waits.
//  piece_stall holds the output register and pauses piece generation.
//  Reset restores block_bytes 64, gap_bytes 0, message_base 0.
//
// ---------------------------------------------------------------------------
module strided_vector_segment_scatter_core #(
	parameter int unsigned MAX_PACKET_BYTES = svs_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write_en,
	input  logic [svs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [svs_pkg::WORD_W-1:0]    cfg_data,
	// packet descriptor channel
	input  logic                          pkt_valid,
	output logic                          pkt_stall,
	input  logic [svs_pkg::WORD_W-1:0]    packet_offset,
	input  logic [svs_pkg::PBYTES_W-1:0]  packet_bytes,
	// piece channel
	output logic                          piece_valid,
	input  logic                          piece_stall,
	output logic [svs_pkg::ADDR_W-1:0]    host_address,
	output logic [svs_pkg::PIECE_W-1:0]   piece_bytes,
	output logic [svs_pkg::POS_W-1:0]     packet_position,
	output logic                          last_piece
);
	import svs_pkg::*;

	svs_cmd_t cmd;
	svs_sts_t sts;

	// Sequencer: idle, divide, emit pieces
	svs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: divide for block index and offset, then walk blocks by pitch
	svs_dpath #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.packet_offset   (packet_offset),
		.packet_bytes    (packet_bytes),
		.cmd             (cmd),
		.sts             (sts),
		.piece_stall     (piece_stall),
		.piece_valid     (piece_valid),
		.host_address    (host_address),
		.piece_bytes     (piece_bytes),
		.packet_position (packet_position),
		.last_piece      (last_piece)
	);

endmodule
`default_nettype wire
